FILE: rtl/kcc_pkg.sv
`timescale 1ns / 1ps

package kcc_pkg;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 8;
    localparam int CODE_W     = 4;
    localparam int CNT_W      = 8;
    localparam int ERR_W      = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS    = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SHORT_RELEASE = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAP_MIN       = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_GAP_MAX       = 4'd3;

    localparam logic [CODE_W-1:0] CODE_NONE  = 4'd10;
    localparam logic [CODE_W-1:0] CODE_MULTI = 4'd11;

    localparam logic [CNT_W:0]   CNT_LIMIT    = 9'd250;
    localparam logic [CNT_W-1:0] CNT_FALLBACK = 8'd200;
    localparam logic [ERR_W-1:0] ERR_LIMIT    = 2'd3;

    localparam logic [CNT_W-1:0] RST_LONG_PRESS    = 8'd100;
    localparam logic [CNT_W-1:0] RST_SHORT_RELEASE = 8'd20;
    localparam logic [CNT_W-1:0] RST_GAP_MIN       = 8'd5;
    localparam logic [CNT_W-1:0] RST_GAP_MAX       = 8'd9;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_SHORT  = 3'd1,
        EV_DOUBLE = 3'd2,
        EV_LONG   = 3'd3,
        EV_ERROR  = 3'd4
    } t_event;

    typedef struct packed {
        logic [CNT_W-1:0] long_press_ticks;
        logic [CNT_W-1:0] short_release_ticks;
        logic [CNT_W-1:0] double_gap_min;
        logic [CNT_W-1:0] double_gap_max;
    } t_cfg;

    typedef struct packed {
        logic [CODE_W-1:0] key;
        t_event            event_res;
    } t_result;

    // Counter increment that falls back to 200 once it passes 250.
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        logic [CNT_W:0] n;
        n = {1'b0, c} + 9'd1;
        if (n > CNT_LIMIT) begin
            return CNT_FALLBACK;
        end
        return n[CNT_W-1:0];
    endfunction

endpackage

FILE: rtl/kcc_cfg_regs.sv
`timescale 1ns / 1ps

module kcc_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [kcc_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [kcc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output kcc_pkg::t_cfg                    o_cfg
);

    kcc_pkg::t_cfg r_cfg;
    kcc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                kcc_pkg::REG_LONG_PRESS:    n_cfg.long_press_ticks    = i_cfg_wdata;
                kcc_pkg::REG_SHORT_RELEASE: n_cfg.short_release_ticks = i_cfg_wdata;
                kcc_pkg::REG_GAP_MIN:       n_cfg.double_gap_min      = i_cfg_wdata;
                kcc_pkg::REG_GAP_MAX:       n_cfg.double_gap_max      = i_cfg_wdata;
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ticks    <= kcc_pkg::RST_LONG_PRESS;
            r_cfg.short_release_ticks <= kcc_pkg::RST_SHORT_RELEASE;
            r_cfg.double_gap_min      <= kcc_pkg::RST_GAP_MIN;
            r_cfg.double_gap_max      <= kcc_pkg::RST_GAP_MAX;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/kcc_core.sv
`timescale 1ns / 1ps

module kcc_core #(
    parameter int NUM_KEYS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [kcc_pkg::CODE_W-1:0]   i_code,
    input  kcc_pkg::t_cfg                i_cfg,
    output kcc_pkg::t_result             o_result
);

    logic [kcc_pkg::CNT_W-1:0]  r_press;
    logic [kcc_pkg::CNT_W-1:0]  r_release;
    logic [kcc_pkg::ERR_W-1:0]  r_error;
    logic [kcc_pkg::CODE_W-1:0] r_last_key;

    logic [kcc_pkg::CNT_W-1:0]  n_press;
    logic [kcc_pkg::CNT_W-1:0]  n_release;
    logic [kcc_pkg::ERR_W-1:0]  n_error;
    logic [kcc_pkg::CODE_W-1:0] n_last_key;

    logic w_is_key;

    assign w_is_key = (i_code != kcc_pkg::CODE_NONE) && (i_code != kcc_pkg::CODE_MULTI)
                      && (i_code < kcc_pkg::CODE_W'(NUM_KEYS));

    always_comb begin
        n_press            = r_press;
        n_release          = r_release;
        n_error            = r_error;
        n_last_key         = r_last_key;
        o_result.event_res = kcc_pkg::EV_NONE;
        o_result.key       = kcc_pkg::CODE_NONE;

        if (i_code == kcc_pkg::CODE_NONE) begin
            n_error   = '0;
            n_release = kcc_pkg::bump(r_release);
            if (n_release >= 8'd2) begin
                if (r_press >= i_cfg.long_press_ticks) begin
                    n_release = i_cfg.short_release_ticks + 8'd1;
                end
                n_press = '0;
                if (n_release == i_cfg.short_release_ticks) begin
                    o_result.event_res = kcc_pkg::EV_SHORT;
                    o_result.key       = r_last_key;
                end
            end
        end else if (w_is_key) begin
            n_error = '0;
            n_press = kcc_pkg::bump(r_press);
            if (n_press >= 8'd2) begin
                if (i_code != r_last_key) begin
                    if (n_press < 8'd4) begin
                        n_last_key = i_code;
                    end
                end else if (r_release > i_cfg.double_gap_max) begin
                    n_release = '0;
                end else if (r_release >= i_cfg.double_gap_min) begin
                    n_press            = i_cfg.long_press_ticks + 8'd1;
                    n_release          = '0;
                    o_result.event_res = kcc_pkg::EV_DOUBLE;
                    o_result.key       = r_last_key;
                end else if (n_press == i_cfg.long_press_ticks) begin
                    o_result.event_res = kcc_pkg::EV_LONG;
                    o_result.key       = r_last_key;
                end
            end
        end else begin
            if (r_error < kcc_pkg::ERR_LIMIT) begin
                n_error = r_error + 2'd1;
            end
            if (n_error >= kcc_pkg::ERR_LIMIT) begin
                n_press            = '0;
                n_release          = kcc_pkg::CNT_FALLBACK;
                n_last_key         = kcc_pkg::CODE_NONE;
                o_result.event_res = kcc_pkg::EV_ERROR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press    <= '0;
            r_release  <= kcc_pkg::CNT_FALLBACK;
            r_error    <= '0;
            r_last_key <= kcc_pkg::CODE_NONE;
        end else if (i_step) begin
            r_press    <= n_press;
            r_release  <= n_release;
            r_error    <= n_error;
            r_last_key <= n_last_key;
        end
    end

    a_error_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (o_result.event_res == kcc_pkg::EV_ERROR)
        |=> (r_press == '0) && (r_release == kcc_pkg::CNT_FALLBACK)
            && (r_last_key == kcc_pkg::CODE_NONE))
        else $error("error reset did not restore the counters");

    a_last_key_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_last_key == kcc_pkg::CODE_NONE) || (r_last_key < kcc_pkg::CODE_W'(NUM_KEYS)))
        else $error("latched key out of range");

endmodule

FILE: rtl/key_click_classifier.sv
`timescale 1ns / 1ps

// Keypad click classifier.
// One scan result per transaction enters on the slave stream (tdata[3:0] is the
// scan code: a key number, 10 for no key, 11 for several keys). Every input
// transaction produces exactly one result transaction on the master stream,
// carrying the event code and the latched key.
// Thresholds are set through the write port (index 0 long press, 1 short
// release, 2 double gap minimum, 3 double gap maximum); write them only while
// no transaction is in flight. Writes to other indexes are ignored.
// An accepted scan is held in an input register, then classified combinationally
// against the press, release and error counters, and the result is held in an
// output register: the result is presented from the output register once the
// scan has passed through the input register, and one scan can be accepted in every cycle while results are taken.
// A synchronous reset clears both stages, restores the default thresholds and
// returns the counters and the latched key to their idle values.
// When the receiver stalls, the result waits in the output register, one more
// scan waits in the input register, and tready then drops until the result is
// taken.

module key_click_classifier #(
    parameter int NUM_KEYS = 10
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [kcc_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [kcc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [7:0]                       i_s_axis_tdata,  // scan_code[3:0], zero[7:4]
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [7:0]                       o_m_axis_tdata   // event_res[2:0], key[6:3], zero[7]
);

    kcc_pkg::t_cfg    w_cfg;
    kcc_pkg::t_result w_res;

    logic                       r_in_valid;
    logic [kcc_pkg::CODE_W-1:0] r_in_code;
    logic                       r_out_valid;
    kcc_pkg::t_result           r_out_res;

    logic w_out_adv;
    logic w_step;

    assign w_out_adv       = !r_out_valid || i_m_axis_tready;
    assign w_step          = r_in_valid && w_out_adv;
    assign o_s_axis_tready = !r_in_valid || w_out_adv;

    kcc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    kcc_core #(
        .NUM_KEYS (NUM_KEYS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_code   (r_in_code),
        .i_cfg    (w_cfg),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_out_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_code <= i_s_axis_tdata[kcc_pkg::CODE_W-1:0];
        end
        if (w_step) begin
            r_out_res <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_res.key, r_out_res.event_res};

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("pipeline not empty after reset");

    a_no_key_without_click: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && ((r_out_res.event_res == kcc_pkg::EV_NONE)
                            || (r_out_res.event_res == kcc_pkg::EV_ERROR))
        |-> (r_out_res.key == kcc_pkg::CODE_NONE))
        else $error("key reported without a click event");

    a_pending_scan_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_out_adv |=> r_in_valid && $stable(r_in_code))
        else $error("stalled scan lost from the input register");

endmodule

FILE: tb/sv/key_click_classifier_tb.sv
`timescale 1ns / 1ps

module key_click_classifier_tb;

    localparam int KEYS = 10;
    localparam int HOLD_CYCLES = 60;
    localparam int SETTLE_CYCLES = 4;

    localparam logic [kcc_pkg::CFG_ADDR_W-1:0] REG_UNMAPPED_LO = 4'd4;
    localparam logic [kcc_pkg::CFG_ADDR_W-1:0] REG_UNMAPPED_HI = 4'd15;
    localparam logic [kcc_pkg::CODE_W-1:0] CODE_UNUSED_LO = 4'd12;
    localparam logic [kcc_pkg::CODE_W-1:0] CODE_UNUSED_HI = 4'd15;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [kcc_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [kcc_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic i_s_axis_tvalid = 1'b0;
    logic o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = '0;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;

    key_click_classifier #(
        .NUM_KEYS(KEYS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [kcc_pkg::CNT_W-1:0] thr_long = kcc_pkg::RST_LONG_PRESS;
    logic [kcc_pkg::CNT_W-1:0] thr_short = kcc_pkg::RST_SHORT_RELEASE;
    logic [kcc_pkg::CNT_W-1:0] thr_gap_min = kcc_pkg::RST_GAP_MIN;
    logic [kcc_pkg::CNT_W-1:0] thr_gap_max = kcc_pkg::RST_GAP_MAX;

    logic [kcc_pkg::CNT_W-1:0] press_ticks = '0;
    logic [kcc_pkg::CNT_W-1:0] release_ticks = kcc_pkg::CNT_FALLBACK;
    logic [kcc_pkg::ERR_W-1:0] multi_run = '0;
    logic [kcc_pkg::CODE_W-1:0] held_key = kcc_pkg::CODE_NONE;

    logic [kcc_pkg::CODE_W-1:0] scan_q[$];
    kcc_pkg::t_result click_q[$];

    int scans_queued = 0;
    int scans_offered = 0;
    int scans_taken = 0;
    int results_seen = 0;
    int errors = 0;
    int settings_run = 0;
    int event_tally[5] = '{default: 0};

    int src_gap_max = 0;
    int sink_stall_max = 0;
    int gap_left = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_mark = 0;
    int stall_left = 0;

    function automatic logic [kcc_pkg::CNT_W-1:0] count_up(
        input logic [kcc_pkg::CNT_W-1:0] c);
        return ({1'b0, c} >= kcc_pkg::CNT_LIMIT) ? kcc_pkg::CNT_FALLBACK : c + 1'b1;
    endfunction

    function automatic kcc_pkg::t_result classify_scan(
        input logic [kcc_pkg::CODE_W-1:0] code);
        kcc_pkg::t_result r;
        r.event_res = kcc_pkg::EV_NONE;
        r.key = kcc_pkg::CODE_NONE;
        if (code == kcc_pkg::CODE_NONE) begin
            multi_run = '0;
            release_ticks = count_up(release_ticks);
            if (release_ticks >= 8'd2) begin
                if (press_ticks >= thr_long) begin
                    release_ticks = thr_short + 8'd1;
                end
                press_ticks = '0;
                if (release_ticks == thr_short) begin
                    r.event_res = kcc_pkg::EV_SHORT;
                    r.key = held_key;
                end
            end
        end else if (code != kcc_pkg::CODE_MULTI && code < kcc_pkg::CODE_W'(KEYS)) begin
            multi_run = '0;
            press_ticks = count_up(press_ticks);
            if (press_ticks >= 8'd2) begin
                if (code != held_key) begin
                    if (press_ticks < 8'd4) begin
                        held_key = code;
                    end
                end else if (release_ticks > thr_gap_max) begin
                    release_ticks = '0;
                end else if (release_ticks >= thr_gap_min) begin
                    press_ticks = thr_long + 8'd1;
                    release_ticks = '0;
                    r.event_res = kcc_pkg::EV_DOUBLE;
                    r.key = held_key;
                end else if (press_ticks == thr_long) begin
                    r.event_res = kcc_pkg::EV_LONG;
                    r.key = held_key;
                end
            end
        end else begin
            if (multi_run < kcc_pkg::ERR_LIMIT) begin
                multi_run = multi_run + 1'b1;
            end
            if (multi_run == kcc_pkg::ERR_LIMIT) begin
                press_ticks = '0;
                release_ticks = kcc_pkg::CNT_FALLBACK;
                held_key = kcc_pkg::CODE_NONE;
                r.event_res = kcc_pkg::EV_ERROR;
            end
        end
        event_tally[r.event_res]++;
        return r;
    endfunction

    // Results are checked before the scan of the same edge is predicted.
    always @(posedge i_clk) begin
        kcc_pkg::t_result want;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                results_seen++;
                if (click_q.size() == 0) begin
                    $error("Result transaction with no scan waiting, tdata %h", o_m_axis_tdata);
                    errors++;
                end else begin
                    want = click_q.pop_front();
                    if (o_m_axis_tdata[2:0] !== want.event_res) begin
                        $error("event_res expected %0d actual %0d",
                               want.event_res, o_m_axis_tdata[2:0]);
                        errors++;
                    end
                    if (o_m_axis_tdata[6:3] !== want.key) begin
                        $error("key expected %0d actual %0d", want.key, o_m_axis_tdata[6:3]);
                        errors++;
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                scans_taken++;
                click_q.push_back(classify_scan(i_s_axis_tdata[kcc_pkg::CODE_W-1:0]));
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && !(i_s_axis_tvalid && scans_taken < scans_offered)) begin
            if (gap_left > 0) begin
                i_s_axis_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (scan_q.size() > 0) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= {4'b0000, scan_q.pop_front()};
                scans_offered++;
                gap_left <= $urandom_range(0, src_gap_max);
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (results_seen != stall_mark) begin
            stall_mark = results_seen;
            stall_left = $urandom_range(0, sink_stall_max);
        end
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [kcc_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [kcc_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            kcc_pkg::REG_LONG_PRESS: thr_long = val;
            kcc_pkg::REG_SHORT_RELEASE: thr_short = val;
            kcc_pkg::REG_GAP_MIN: thr_gap_min = val;
            kcc_pkg::REG_GAP_MAX: thr_gap_max = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (scan_q.size() != 0 || scans_taken != scans_offered || click_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic queue_run(input logic [kcc_pkg::CODE_W-1:0] code, input int n);
        repeat (n) begin
            scan_q.push_back(code);
            scans_queued++;
        end
    endtask

    function automatic int press_len();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            return $urandom_range(1, 6);
        end
        if (pick < 8) begin
            return $urandom_range(thr_long > 2 ? thr_long - 2 : 1, thr_long + 3);
        end
        return $urandom_range(1, thr_long + 10);
    endfunction

    function automatic int release_len();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            return $urandom_range(1, 4);
        end
        if (pick < 7) begin
            return $urandom_range(thr_short > 1 ? thr_short - 1 : 1, thr_short + 2);
        end
        return $urandom_range(1, thr_gap_max + 3);
    endfunction

    task automatic queue_gesture();
        int pick;
        int k;
        int other;
        int lo;
        int hi;
        pick = $urandom_range(0, 99);
        k = $urandom_range(0, KEYS - 1);
        if (pick < 50) begin
            queue_run(kcc_pkg::CODE_W'(k), press_len());
            queue_run(kcc_pkg::CODE_NONE, release_len());
        end else if (pick < 75) begin
            // A press, a gap near the double-click window, then the same key again and a release.
            lo = (thr_gap_min > 1) ? thr_gap_min - 1 : 1;
            hi = thr_gap_max + 1;
            if (hi < lo) begin
                hi = lo + 2;
            end
            queue_run(kcc_pkg::CODE_W'(k), $urandom_range(2, 5));
            queue_run(kcc_pkg::CODE_NONE, $urandom_range(lo, hi));
            queue_run(kcc_pkg::CODE_W'(k), $urandom_range(2, 5));
            queue_run(kcc_pkg::CODE_NONE, release_len());
        end else if (pick < 85) begin
            repeat ($urandom_range(1, 4)) begin
                queue_run(kcc_pkg::CODE_W'($urandom_range(kcc_pkg::CODE_MULTI,
                                                          CODE_UNUSED_HI)), 1);
            end
            // A long quiet stretch can push the release counter past its limit.
            if ($urandom_range(0, 1) == 1) begin
                queue_run(kcc_pkg::CODE_NONE, $urandom_range(45, 60));
            end
        end else if (pick < 93) begin
            other = (k + $urandom_range(1, KEYS - 1)) % KEYS;
            queue_run(kcc_pkg::CODE_W'(k), $urandom_range(1, 4));
            queue_run(kcc_pkg::CODE_W'(other), $urandom_range(1, 6));
            queue_run(kcc_pkg::CODE_NONE, release_len());
        end else begin
            repeat ($urandom_range(1, 6)) begin
                queue_run(kcc_pkg::CODE_W'($urandom_range(0, CODE_UNUSED_HI)), 1);
            end
        end
    endtask

    task automatic run_phase(input logic [kcc_pkg::CNT_W-1:0] long_v,
                             input logic [kcc_pkg::CNT_W-1:0] short_v,
                             input logic [kcc_pkg::CNT_W-1:0] gmin_v,
                             input logic [kcc_pkg::CNT_W-1:0] gmax_v,
                             input int budget, input int gap_v, input int stall_v,
                             input bit squeeze);
        int start;
        write_reg(kcc_pkg::REG_LONG_PRESS, long_v);
        write_reg(kcc_pkg::REG_SHORT_RELEASE, short_v);
        write_reg(kcc_pkg::REG_GAP_MIN, gmin_v);
        write_reg(kcc_pkg::REG_GAP_MAX, gmax_v);
        src_gap_max = gap_v;
        sink_stall_max = stall_v;
        settings_run++;
        @(posedge i_clk);
        start = scans_queued;
        while (scans_queued - start < budget / 2) begin
            queue_gesture();
        end
        if (squeeze) begin
            hold_reqs++;
        end
        wait_idle();
        @(posedge i_clk);
        while (scans_queued - start < budget) begin
            queue_gesture();
        end
        wait_idle();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(kcc_pkg::REG_LONG_PRESS, 8'd4);
        write_reg(kcc_pkg::REG_SHORT_RELEASE, 8'd6);
        write_reg(kcc_pkg::REG_GAP_MIN, 8'd2);
        write_reg(kcc_pkg::REG_GAP_MAX, 8'd3);
        write_reg(REG_UNMAPPED_LO, 8'd50);
        write_reg(REG_UNMAPPED_HI, 8'd255);
        src_gap_max = 18;
        sink_stall_max = 18;
        settings_run++;
        @(posedge i_clk);
        queue_run(kcc_pkg::CODE_W'(KEYS - 1), 4);
        queue_run(kcc_pkg::CODE_NONE, 2);
        queue_run(kcc_pkg::CODE_W'(KEYS - 1), 2);
        queue_run(kcc_pkg::CODE_NONE, 8);
        queue_run(4'd0, 3);
        queue_run(kcc_pkg::CODE_NONE, 2);
        queue_run(4'd0, 2);
        queue_run(kcc_pkg::CODE_MULTI, 1);
        queue_run(CODE_UNUSED_LO, 1);
        queue_run(CODE_UNUSED_HI, 2);
        queue_run(4'd0, 1);
        wait_idle();

        run_phase(kcc_pkg::RST_LONG_PRESS, kcc_pkg::RST_SHORT_RELEASE,
                  kcc_pkg::RST_GAP_MIN, kcc_pkg::RST_GAP_MAX, 300, 18, 18, 1'b0);
        run_phase(8'd3, 8'd3, 8'd2, 8'd2, 300, 0, 0, 1'b1);
        run_phase(8'd199, 8'd199, 8'd199, 8'd199, 120, 4, 18, 1'b0);
        run_phase(kcc_pkg::CNT_W'($urandom_range(3, 20)), kcc_pkg::CNT_W'($urandom_range(3, 25)),
                  kcc_pkg::CNT_W'($urandom_range(2, 8)), kcc_pkg::CNT_W'($urandom_range(2, 12)),
                  250, 18, 3, 1'b0);
        run_phase(kcc_pkg::CNT_W'($urandom_range(3, 20)), kcc_pkg::CNT_W'($urandom_range(3, 25)),
                  kcc_pkg::CNT_W'($urandom_range(2, 8)), kcc_pkg::CNT_W'($urandom_range(2, 12)),
                  250, 0, 18, 1'b0);
        run_phase(8'd255, 8'd255, 8'd2, 8'd9, 60, 10, 10, 1'b0);
        run_phase(kcc_pkg::CNT_W'($urandom_range(3, 20)), kcc_pkg::CNT_W'($urandom_range(3, 25)),
                  kcc_pkg::CNT_W'($urandom_range(2, 8)), kcc_pkg::CNT_W'($urandom_range(2, 12)),
                  150, 18, 18, 1'b0);

        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("Classified %0d scans under %0d threshold settings, %0d results checked.",
                 scans_taken, settings_run, results_seen);
        $display("Clicks seen: %0d short, %0d double, %0d long, %0d error resets.",
                 event_tally[kcc_pkg::EV_SHORT], event_tally[kcc_pkg::EV_DOUBLE],
                 event_tally[kcc_pkg::EV_LONG], event_tally[kcc_pkg::EV_ERROR]);
        if (errors == 0) begin
            $display("key_click_classifier_tb OK");
        end else begin
            $display("key_click_classifier_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d results still expected.", click_q.size());
        $display("key_click_classifier_tb NOT OK");
        $finish;
    end

endmodule
